// ===== design/ptc_pkg.sv =====
// Shared types and constants for the pressure/temperature compensation core.
package ptc_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_COEF_FIRST  = 3'd0;
  localparam logic [2:0] REG_COEF_SECOND = 3'd1;
  localparam logic [2:0] REG_COEF_LAST   = 3'd2;
  localparam logic [2:0] REG_TEMP_OSR    = 3'd3;
  localparam logic [2:0] REG_PRS_OSR     = 3'd4;

  localparam logic [2:0] OSR_RESET = 3'd3;

  // Scaling divider: 36 dividend bits, 4 quotient bits per cycle
  localparam int DIV_BITS      = 36;
  localparam int DIV_PER_CYCLE = 4;
  localparam int DIV_STEPS     = DIV_BITS / DIV_PER_CYCLE;

  // Multiplier operand widths (A is split into two halves)
  localparam int MAC_A_W    = 56;
  localparam int MAC_HALF_W = MAC_A_W / 2;
  localparam int MAC_B_W    = 32;
  localparam int MAC_PP_W   = MAC_HALF_W + MAC_B_W;
  localparam int MAC_PROD_W = MAC_A_W + MAC_B_W;
  localparam int FRAC_BITS  = 24;

  typedef struct packed {
    logic                      start;
    logic signed [MAC_A_W-1:0] a;
    logic signed [MAC_B_W-1:0] b;
    logic signed [63:0]        addend;
  } mac_cmd_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] result;
  } mac_rsp_t;

  // Each scaling factor is m * 2^k; 2^24 / factor reduces to 2^(24-k) / m.
  function automatic logic [7:0] osr_divisor(input logic [2:0] code);
    logic [7:0] m;
    case (code)
      3'd0:    m = 8'd1;
      3'd1:    m = 8'd3;
      3'd2:    m = 8'd7;
      3'd3:    m = 8'd15;
      3'd4:    m = 8'd31;
      3'd5:    m = 8'd63;
      3'd6:    m = 8'd127;
      3'd7:    m = 8'd255;
      default: m = 8'd1;
    endcase
    return m;
  endfunction

  // Codes 4..7 have k = 13 (shift 11), codes 0..3 have k = 19 (shift 5)
  function automatic logic osr_long_shift(input logic [2:0] code);
    return code[2];
  endfunction

endpackage

// ===== design/ptc_div.sv =====
// Iterative divider that scales a raw result into Q24 by the oversampling factor.
module ptc_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [23:0] raw,
  input  logic [2:0]         code,
  output logic               done,
  output logic signed [31:0] quot
);
  import ptc_pkg::*;

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} div_state_t;

  div_state_t            state;
  logic                  neg;
  logic [DIV_BITS-1:0]   work;
  logic [DIV_BITS-1:0]   work_next;
  logic [7:0]            rem;
  logic [7:0]            rem_next;
  logic [7:0]            divisor;
  logic [3:0]            count;
  logic [23:0]           raw_mag;
  logic [DIV_BITS-1:0]   dividend;

  assign raw_mag  = raw[23] ? 24'(-raw) : 24'(raw);
  assign dividend = osr_long_shift(code) ? {1'b0, raw_mag, 11'b0} : {7'b0, raw_mag, 5'b0};

  // Restoring division, dividend shifted out the top, quotient shifted in below
  always_comb begin : div_iter
    logic [DIV_BITS-1:0] w;
    logic [7:0]          r;
    logic [8:0]          trial;
    w = work;
    r = rem;
    for (int i = 0; i < DIV_PER_CYCLE; i++) begin
      trial = {r, w[DIV_BITS-1]};
      w     = {w[DIV_BITS-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        r    = 8'(trial - {1'b0, divisor});
        w[0] = 1'b1;
      end else begin
        r = trial[7:0];
      end
    end
    work_next = w;
    rem_next  = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == D_FIN);
      case (state)
        D_IDLE: begin
          if (start) begin
            neg     <= raw[23];
            work    <= dividend;
            rem     <= '0;
            divisor <= osr_divisor(code);
            count   <= 4'(DIV_STEPS - 1);
            state   <= D_RUN;
          end
        end
        D_RUN: begin
          work <= work_next;
          rem  <= rem_next;
          if (count == '0) begin
            state <= D_FIN;
          end else begin
            count <= count - 4'd1;
          end
        end
        D_FIN: begin
          // quotient stays below 2^30, truncation toward zero via magnitude
          quot  <= neg ? 32'(-work[31:0]) : work[31:0];
          state <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

// ===== design/ptc_mac.sv =====
// Shared multiply unit: addend + trunc(a * b / 2^24), over two half-width products.
module ptc_mac (
  input  logic              clk,
  input  logic              rst,
  input  ptc_pkg::mac_cmd_t cmd,
  output ptc_pkg::mac_rsp_t rsp
);
  import ptc_pkg::*;

  typedef enum logic [2:0] {M_IDLE, M_LO, M_HI, M_SUM, M_FIN} mac_state_t;

  mac_state_t             state;
  logic [MAC_A_W-1:0]     mag_a;
  logic [MAC_B_W-1:0]     mag_b;
  logic                   neg;
  logic signed [63:0]     addend;
  logic [MAC_PP_W-1:0]    pp;
  logic [MAC_PROD_W-1:0]  acc;
  logic [63:0]            q_mag;

  assign q_mag = acc[FRAC_BITS +: 64];

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= M_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= (state == M_FIN);
      case (state)
        M_IDLE: begin
          if (cmd.start) begin
            mag_a  <= cmd.a[MAC_A_W-1] ? MAC_A_W'(-cmd.a) : MAC_A_W'(cmd.a);
            mag_b  <= cmd.b[MAC_B_W-1] ? MAC_B_W'(-cmd.b) : MAC_B_W'(cmd.b);
            neg    <= cmd.a[MAC_A_W-1] ^ cmd.b[MAC_B_W-1];
            addend <= cmd.addend;
            state  <= M_LO;
          end
        end
        M_LO: begin
          pp    <= MAC_PP_W'(mag_a[MAC_HALF_W-1:0]) * MAC_PP_W'(mag_b);
          state <= M_HI;
        end
        M_HI: begin
          acc   <= {{(MAC_PROD_W - MAC_PP_W){1'b0}}, pp};
          pp    <= MAC_PP_W'(mag_a[MAC_A_W-1:MAC_HALF_W]) * MAC_PP_W'(mag_b);
          state <= M_SUM;
        end
        M_SUM: begin
          acc   <= acc + {pp, {MAC_HALF_W{1'b0}}};
          state <= M_FIN;
        end
        M_FIN: begin
          // sign applied to the truncated magnitude: rounds toward zero
          rsp.result <= addend + (q_mag ^ {64{neg}}) + {63'b0, neg};
          state      <= M_IDLE;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

// ===== design/pressure_temperature_compensation_core.sv =====
// Top level: config registers, step sequencer, Q8 conversion and result register.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+--------------------------------------
//  item     | item_valid / item_stall    | mode, raw_value
//  result   | result_valid / result_stall| result_kind, compensated
//  config   | cfg_write                  | cfg_index, cfg_data
//
// Temperature and pressure items each pass the scaling divider, then the
// shared multiplier: the divider works 4 quotient bits per iteration, and the
// multiplier runs one step for temperature and six for pressure.
// One item is worked at a time; the next one is taken while a result waits.
// Reset is synchronous: coefficients clear, oversampling codes return to 3.
module pressure_temperature_compensation_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic               mode,
  input  logic signed [23:0] raw_value,
  output logic               result_valid,
  input  logic               result_stall,
  output logic               result_kind,
  output logic signed [31:0] compensated,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);
  import ptc_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_MAC_GO, S_MAC_WAIT, S_DONE} state_t;
  typedef enum logic [2:0] {
    STEP_T, STEP_H3, STEP_H2, STEP_H1, STEP_G2, STEP_G1, STEP_V
  } step_t;

  logic [63:0]        coef_first;
  logic [63:0]        coef_second;
  logic [15:0]        coef_last;
  logic [2:0]         temp_ovs;
  logic [2:0]         prs_osr;
  logic [143:0]       coef_all;

  state_t             state;
  step_t              step;
  logic               kind;
  logic signed [31:0] scaled;
  logic signed [31:0] last_temp;
  logic signed [63:0] h;
  logic signed [63:0] g;

  logic               div_start;
  logic               div_done;
  logic signed [31:0] div_quot;
  mac_cmd_t           mac_cmd;
  mac_rsp_t           mac_rsp;

  logic [11:0] c0, c1, c0h;
  logic [12:0] c0_adj;
  logic [19:0] c00, c10;
  logic [15:0] c01, c11, c20, c21, c30;

  logic [63:0]        v_adj;
  logic [47:0]        q8_wide;
  logic signed [31:0] q8_sat;
  logic               out_load;

  function automatic logic [MAC_A_W-1:0] q24_op(input logic [19:0] k);
    return {{(MAC_A_W - 20 - FRAC_BITS){k[19]}}, k, {FRAC_BITS{1'b0}}};
  endfunction

  function automatic logic [63:0] q24_add(input logic [19:0] k);
    return {{(64 - 20 - FRAC_BITS){k[19]}}, k, {FRAC_BITS{1'b0}}};
  endfunction

  // Coefficient unpack, byte 0 at the top
  assign coef_all = {coef_first, coef_second, coef_last};
  assign c0  = coef_all[143:132];
  assign c1  = coef_all[131:120];
  assign c00 = coef_all[119:100];
  assign c10 = coef_all[99:80];
  assign c01 = coef_all[79:64];
  assign c11 = coef_all[63:48];
  assign c20 = coef_all[47:32];
  assign c21 = coef_all[31:16];
  assign c30 = coef_all[15:0];

  // c0 / 2 truncated toward zero: add one when negative, then shift
  assign c0_adj = {c0[11], c0} + {12'b0, c0[11]};
  assign c0h    = c0_adj[12:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_first  <= '0;
      coef_second <= '0;
      coef_last   <= '0;
      temp_ovs    <= OSR_RESET;
      prs_osr     <= OSR_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_COEF_FIRST:  coef_first  <= cfg_data;
        REG_COEF_SECOND: coef_second <= cfg_data;
        REG_COEF_LAST:   coef_last   <= cfg_data[15:0];
        REG_TEMP_OSR:    temp_ovs    <= cfg_data[2:0];
        REG_PRS_OSR:     prs_osr     <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign item_stall = (state != S_IDLE);
  assign div_start  = (state == S_IDLE) && item_valid;

  ptc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .raw   (raw_value),
    .code  (mode ? prs_osr : temp_ovs),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Horner chain: h = c20 + p*c30, c10 + p*h, c00 + p*h; g = c11 + p*c21,
  // c01 + p*g; then v = h + T*g. Coefficients enter as Q24 operands.
  always_comb begin
    mac_cmd.start = (state == S_MAC_GO);
    case (step)
      STEP_T: begin
        mac_cmd.a      = q24_op({{8{c1[11]}}, c1});
        mac_cmd.b      = scaled;
        mac_cmd.addend = q24_add({{8{c0h[11]}}, c0h});
      end
      STEP_H3: begin
        mac_cmd.a      = q24_op({{4{c30[15]}}, c30});
        mac_cmd.b      = scaled;
        mac_cmd.addend = q24_add({{4{c20[15]}}, c20});
      end
      STEP_H2: begin
        mac_cmd.a      = h[MAC_A_W-1:0];
        mac_cmd.b      = scaled;
        mac_cmd.addend = q24_add(c10);
      end
      STEP_H1: begin
        mac_cmd.a      = h[MAC_A_W-1:0];
        mac_cmd.b      = scaled;
        mac_cmd.addend = q24_add(c00);
      end
      STEP_G2: begin
        mac_cmd.a      = q24_op({{4{c21[15]}}, c21});
        mac_cmd.b      = scaled;
        mac_cmd.addend = q24_add({{4{c11[15]}}, c11});
      end
      STEP_G1: begin
        mac_cmd.a      = g[MAC_A_W-1:0];
        mac_cmd.b      = scaled;
        mac_cmd.addend = q24_add({{4{c01[15]}}, c01});
      end
      STEP_V: begin
        mac_cmd.a      = g[MAC_A_W-1:0];
        mac_cmd.b      = last_temp;
        mac_cmd.addend = h;
      end
      default: begin
        mac_cmd.a      = '0;
        mac_cmd.b      = '0;
        mac_cmd.addend = '0;
      end
    endcase
  end

  ptc_mac u_mac (
    .clk (clk),
    .rst (rst),
    .cmd (mac_cmd),
    .rsp (mac_rsp)
  );

  // Q24 to Q8, truncated toward zero, then clamped to 32 bits
  assign v_adj   = h + {48'b0, {16{h[63]}}};
  assign q8_wide = v_adj[63:16];
  always_comb begin
    if (q8_wide[47:31] == {17{q8_wide[47]}}) begin
      q8_sat = q8_wide[31:0];
    end else begin
      q8_sat = q8_wide[47] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
    end
  end

  // result register loads once the previous item has left or is leaving
  assign out_load = (state == S_DONE) && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step         <= STEP_T;
      result_valid <= 1'b0;
      last_temp    <= '0;
    end else begin
      if (out_load) begin
        result_valid <= 1'b1;
        result_kind  <= kind;
        compensated  <= q8_sat;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            kind  <= mode;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            scaled <= div_quot;
            if (kind) begin
              step <= STEP_H3;
            end else begin
              last_temp <= div_quot;
              step      <= STEP_T;
            end
            state <= S_MAC_GO;
          end
        end
        S_MAC_GO: state <= S_MAC_WAIT;
        S_MAC_WAIT: begin
          if (mac_rsp.done) begin
            case (step)
              STEP_T: begin
                h     <= mac_rsp.result;
                state <= S_DONE;
              end
              STEP_H3: begin
                h     <= mac_rsp.result;
                step  <= STEP_H2;
                state <= S_MAC_GO;
              end
              STEP_H2: begin
                h     <= mac_rsp.result;
                step  <= STEP_H1;
                state <= S_MAC_GO;
              end
              STEP_H1: begin
                h     <= mac_rsp.result;
                step  <= STEP_G2;
                state <= S_MAC_GO;
              end
              STEP_G2: begin
                g     <= mac_rsp.result;
                step  <= STEP_G1;
                state <= S_MAC_GO;
              end
              STEP_G1: begin
                g     <= mac_rsp.result;
                step  <= STEP_V;
                state <= S_MAC_GO;
              end
              STEP_V: begin
                h     <= mac_rsp.result;
                state <= S_DONE;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
